// ----- rtl/smfp_pkg.sv -----
`default_nettype none
package smfp_pkg;

    localparam int SMFP_QUEUE_DEPTH = 2;

    // Event kinds.
    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_LOCAL  = 3'd1;
    localparam logic [2:0] EV_STACK  = 3'd2;
    localparam logic [2:0] EV_END    = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // Frame classes.
    localparam logic [2:0] CLS_SAME     = 3'd0;
    localparam logic [2:0] CLS_ONE      = 3'd1;
    localparam logic [2:0] CLS_ONE_EXT  = 3'd2;
    localparam logic [2:0] CLS_CHOP     = 3'd3;
    localparam logic [2:0] CLS_SAME_EXT = 3'd4;
    localparam logic [2:0] CLS_APPEND   = 3'd5;
    localparam logic [2:0] CLS_FULL     = 3'd6;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_RESERVED = 2'd1;
    localparam logic [1:0] ERR_TAG      = 2'd2;

    // Verification tag groups.
    localparam logic [1:0] TAG_SIMPLE  = 2'd0;
    localparam logic [1:0] TAG_INDEXED = 2'd1;
    localparam logic [1:0] TAG_BAD     = 2'd2;

    localparam logic [7:0] TYPE_FULL = 8'd255;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [2:0]  frame_class;
        logic [7:0]  frame_type_raw;
        logic [15:0] frame_offset;
        logic [3:0]  type_tag;
        logic [15:0] tag_operand;
        logic [1:0]  error_code;
        logic        frame_done;
    } t_out_item;

    // A byte as the front end sees it: both its reading as a frame type
    // and its reading as a verification tag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic [2:0] tb_class;
        logic       tb_reserved;
        logic [1:0] tag_kind;
    } t_token;

endpackage
`default_nettype wire

// ----- rtl/smfp_front.sv -----
`default_nettype none
module smfp_front (
    input  wire logic            i_valid,
    input  wire smfp_pkg::t_in_item i_item,
    input  wire logic            i_q_full,
    output logic                 o_stall,
    output logic                 o_push,
    output smfp_pkg::t_token     o_token
);
    import smfp_pkg::*;

    logic [7:0] b;

    assign b       = i_item.data_byte;
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_token.data_byte   = b;
        o_token.restart     = i_item.restart;
        o_token.tb_reserved = 1'b0;
        if (b inside {[8'd0:8'd63]}) begin
            o_token.tb_class = CLS_SAME;
        end else if (b inside {[8'd64:8'd127]}) begin
            o_token.tb_class = CLS_ONE;
        end else if (b == 8'd247) begin
            o_token.tb_class = CLS_ONE_EXT;
        end else if (b inside {[8'd248:8'd250]}) begin
            o_token.tb_class = CLS_CHOP;
        end else if (b == 8'd251) begin
            o_token.tb_class = CLS_SAME_EXT;
        end else if (b inside {[8'd252:8'd254]}) begin
            o_token.tb_class = CLS_APPEND;
        end else if (b == TYPE_FULL) begin
            o_token.tb_class = CLS_FULL;
        end else begin
            o_token.tb_class    = CLS_SAME;
            o_token.tb_reserved = 1'b1;
        end

        if (b <= 8'd6) begin
            o_token.tag_kind = TAG_SIMPLE;
        end else if (b <= 8'd8) begin
            o_token.tag_kind = TAG_INDEXED;
        end else begin
            o_token.tag_kind = TAG_BAD;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/smfp_queue.sv -----
`default_nettype none
module smfp_queue #(
    parameter int QueueDepth = smfp_pkg::SMFP_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire smfp_pkg::t_token i_token,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output smfp_pkg::t_token      o_token
);
    import smfp_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

    t_token          r_mem [QueueDepth];
    logic [PtrW-1:0] r_wptr, n_wptr;
    logic [PtrW-1:0] r_rptr, n_rptr;
    logic [CntW-1:0] r_cnt,  n_cnt;

    assign o_full  = (r_cnt == FullCnt);
    assign o_valid = (r_cnt != '0);
    assign o_token = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == LastPtr) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LastPtr) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_token;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/smfp_back.sv -----
`default_nettype none
module smfp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire smfp_pkg::t_token i_token,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output smfp_pkg::t_out_item   o_item
);
    import smfp_pkg::*;

    localparam logic [3:0] PH_TYPE = 4'd0;
    localparam logic [3:0] PH_DHI  = 4'd1;
    localparam logic [3:0] PH_DLO  = 4'd2;
    localparam logic [3:0] PH_LHI  = 4'd3;
    localparam logic [3:0] PH_LLO  = 4'd4;
    localparam logic [3:0] PH_SHI  = 4'd5;
    localparam logic [3:0] PH_SLO  = 4'd6;
    localparam logic [3:0] PH_VTAG = 4'd7;
    localparam logic [3:0] PH_IHI  = 4'd8;
    localparam logic [3:0] PH_ILO  = 4'd9;

    logic [3:0]  r_phase,  n_phase;
    logic [7:0]  r_cur,    n_cur;
    logic [2:0]  r_cls,    n_cls;
    logic [15:0] r_delta,  n_delta;
    logic [15:0] r_locals, n_locals;
    logic [15:0] r_stack,  n_stack;
    logic [7:0]  r_hold,   n_hold;
    logic [3:0]  r_ptag,   n_ptag;
    logic        r_in_stack, n_in_stack;
    logic        r_err,    n_err;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        emit;
    logic        type_ev;
    logic [2:0]  ev_kind;
    logic [3:0]  ev_tag;
    logic [15:0] ev_index;
    logic [1:0]  ev_err;
    logic        ev_done;
    logic [3:0]  phase_eff;
    logic        err_eff;
    logic [7:0]  b;
    t_out_item   n_item;

    assign b       = i_token.data_byte;
    assign o_pop   = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    always_comb begin
        n_phase    = r_phase;
        n_cur      = r_cur;
        n_cls      = r_cls;
        n_delta    = r_delta;
        n_locals   = r_locals;
        n_stack    = r_stack;
        n_hold     = r_hold;
        n_ptag     = r_ptag;
        n_in_stack = r_in_stack;
        n_err      = r_err;
        emit       = 1'b0;
        type_ev    = 1'b0;
        ev_kind    = EV_HEADER;
        ev_tag     = '0;
        ev_index   = '0;
        ev_err     = ERR_NONE;
        ev_done    = 1'b0;
        phase_eff  = i_token.restart ? PH_TYPE : r_phase;
        err_eff    = i_token.restart ? 1'b0 : r_err;

        if (o_pop) begin
            n_phase = phase_eff;
            n_err   = err_eff;
            if (!err_eff) begin
                case (phase_eff)
                    PH_DHI: begin
                        n_hold  = b;
                        n_phase = PH_DLO;
                    end
                    PH_DLO: begin
                        n_delta = {r_hold, b};
                        emit    = 1'b1;
                        case (r_cls)
                            CLS_ONE_EXT: begin
                                n_stack    = 16'd1;
                                n_in_stack = 1'b1;
                                n_phase    = PH_VTAG;
                            end
                            CLS_APPEND: begin
                                // Append types 252..254 carry one to three locals.
                                n_locals   = {14'd0, r_cur[1:0]} + 16'd1;
                                n_in_stack = 1'b0;
                                n_phase    = PH_VTAG;
                            end
                            CLS_FULL: begin
                                n_phase = PH_LHI;
                            end
                            default: begin
                                n_phase = PH_TYPE;
                                ev_done = 1'b1;
                            end
                        endcase
                    end
                    PH_LHI: begin
                        n_hold  = b;
                        n_phase = PH_LLO;
                    end
                    PH_LLO: begin
                        n_locals   = {r_hold, b};
                        n_in_stack = 1'b0;
                        n_phase    = ({r_hold, b} != 16'd0) ? PH_VTAG : PH_SHI;
                    end
                    PH_SHI: begin
                        n_hold  = b;
                        n_phase = PH_SLO;
                    end
                    PH_SLO: begin
                        n_stack = {r_hold, b};
                        if ({r_hold, b} == 16'd0) begin
                            emit    = 1'b1;
                            ev_kind = EV_END;
                            ev_done = 1'b1;
                            n_phase = PH_TYPE;
                        end else begin
                            n_in_stack = 1'b1;
                            n_phase    = PH_VTAG;
                        end
                    end
                    PH_VTAG: begin
                        case (i_token.tag_kind)
                            TAG_SIMPLE: begin
                                type_ev = 1'b1;
                                ev_tag  = b[3:0];
                            end
                            TAG_INDEXED: begin
                                n_ptag  = b[3:0];
                                n_phase = PH_IHI;
                            end
                            default: begin
                                emit    = 1'b1;
                                ev_kind = EV_ERROR;
                                ev_err  = ERR_TAG;
                                ev_done = 1'b1;
                                n_err   = 1'b1;
                                n_phase = PH_TYPE;
                            end
                        endcase
                    end
                    PH_IHI: begin
                        n_hold  = b;
                        n_phase = PH_ILO;
                    end
                    PH_ILO: begin
                        type_ev  = 1'b1;
                        ev_tag   = r_ptag;
                        ev_index = {r_hold, b};
                    end
                    default: begin
                        // Frame type byte; unused phase codes land here too.
                        n_cur = b;
                        n_cls = i_token.tb_class;
                        if (i_token.tb_reserved) begin
                            n_delta = '0;
                            n_err   = 1'b1;
                            n_phase = PH_TYPE;
                            emit    = 1'b1;
                            ev_kind = EV_ERROR;
                            ev_err  = ERR_RESERVED;
                            ev_done = 1'b1;
                        end else if (!b[7]) begin
                            n_delta = {10'd0, b[5:0]};
                            emit    = 1'b1;
                            if (b[6]) begin
                                n_stack    = 16'd1;
                                n_in_stack = 1'b1;
                                n_phase    = PH_VTAG;
                            end else begin
                                n_phase = PH_TYPE;
                                ev_done = 1'b1;
                            end
                        end else begin
                            n_phase = PH_DHI;
                        end
                    end
                endcase

                if (type_ev) begin
                    emit = 1'b1;
                    if (r_in_stack) begin
                        ev_kind = EV_STACK;
                        n_stack = r_stack - 16'd1;
                        if (r_stack == 16'd1) begin
                            ev_done = 1'b1;
                            n_phase = PH_TYPE;
                        end else begin
                            n_phase = PH_VTAG;
                        end
                    end else begin
                        ev_kind  = EV_LOCAL;
                        n_locals = r_locals - 16'd1;
                        if (r_locals != 16'd1) begin
                            n_phase = PH_VTAG;
                        end else if (r_cur == TYPE_FULL) begin
                            n_phase = PH_SHI;
                        end else begin
                            ev_done = 1'b1;
                            n_phase = PH_TYPE;
                        end
                    end
                end
            end
        end

        n_item.event_kind     = ev_kind;
        n_item.frame_class    = n_cls;
        n_item.frame_type_raw = n_cur;
        n_item.frame_offset   = n_delta;
        n_item.type_tag       = ev_tag;
        n_item.tag_operand    = ev_index;
        n_item.error_code     = ev_err;
        n_item.frame_done     = ev_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_cur       <= '0;
            r_cls       <= CLS_SAME;
            r_delta     <= '0;
            r_locals    <= '0;
            r_stack     <= '0;
            r_hold      <= '0;
            r_ptag      <= '0;
            r_in_stack  <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cur      <= n_cur;
            r_cls      <= n_cls;
            r_delta    <= n_delta;
            r_locals   <= n_locals;
            r_stack    <= n_stack;
            r_hold     <= n_hold;
            r_ptag     <= n_ptag;
            r_in_stack <= n_in_stack;
            r_err      <= n_err;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/stack_map_frame_parser.sv -----
`default_nettype none
// Stack map frame parser: takes a big-endian frame stream one byte per item and
// gives at most one event item per byte (header, local type, stack type, frame
// end or error). It sustains one byte and one event per cycle unless stalled;
// an accepted byte goes through the queue into the event register. The front
// end classifies each byte and writes it into a QueueDepth-entry queue; the
// back end takes one queued byte per cycle whenever its output register is empty
// or being drained, so o_in_stall rises only when the queue is full. After an
// error event the parser drops bytes until one arrives with restart set.
module stack_map_frame_parser #(
    parameter int QueueDepth = smfp_pkg::SMFP_QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire smfp_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output smfp_pkg::t_out_item      o_out_item
);
    import smfp_pkg::*;

    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    t_token front_token;
    t_token head_token;

    smfp_front u_front (
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .i_q_full (q_full),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_token  (front_token)
    );

    smfp_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_token (head_token)
    );

    smfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_token   (head_token),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule
`default_nettype wire

// ----- rtl/smfp_chk.sv -----
`default_nettype none
module smfp_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire smfp_pkg::t_out_item o_out_item
);
    import smfp_pkg::*;

    // A stalled item stays offered.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("output item changed while stalled");

    // Every error closes its frame and carries a code.
    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == EV_ERROR
        |-> o_out_item.frame_done && o_out_item.error_code != ERR_NONE)
        else $error("error item without code or frame end");

    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind != EV_ERROR
        |-> o_out_item.error_code == ERR_NONE)
        else $error("error code on a non-error item");

    // Only a full frame with an empty stack list ends with a separate end item.
    a_end_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == EV_END
        |-> o_out_item.frame_class == CLS_FULL && o_out_item.frame_done)
        else $error("end item outside a full frame");

endmodule

bind stack_map_frame_parser smfp_chk u_smfp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire

// ----- tb/stack_map_frame_parser_tb.sv -----
`default_nettype none
module stack_map_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smfp_pkg::*;

    // Frame type byte boundaries.
    localparam logic [7:0] SAME_MAX      = 8'd63;
    localparam logic [7:0] ONE_MAX       = 8'd127;
    localparam logic [7:0] ONE_OFFSET    = 8'd64;
    localparam logic [7:0] RESERVED_MAX  = 8'd246;
    localparam logic [7:0] ONE_EXT_TYPE  = 8'd247;
    localparam logic [7:0] CHOP_MAX      = 8'd250;
    localparam logic [7:0] SAME_EXT_TYPE = 8'd251;
    localparam logic [7:0] APPEND_MAX    = 8'd254;

    // Verification tag boundaries.
    localparam logic [7:0] VTAG_PLAIN_MAX = 8'd6;
    localparam logic [7:0] VTAG_INDEX_MAX = 8'd8;

    localparam int PHASE_ITEMS = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        P_TYPE, P_DHI, P_DLO, P_LHI, P_LLO, P_SHI, P_SLO, P_VTAG, P_IHI, P_ILO
    } t_parse_phase;

    class frame_event_scoreboard;
        t_parse_phase phase = P_TYPE;
        logic [7:0]   type_byte = '0;
        logic [15:0]  delta = '0;
        logic [15:0]  locals_left = '0;
        logic [15:0]  stack_left = '0;
        logic [7:0]   hi_hold = '0;
        logic [3:0]   tag_hold = '0;
        bit           in_stack = 1'b0;
        bit           err_hold = 1'b0;
        t_out_item    expected_events[$];
        int           mismatches = 0;

        function logic [2:0] class_of(logic [7:0] t);
            if (t <= SAME_MAX) return CLS_SAME;
            if (t <= ONE_MAX) return CLS_ONE;
            if (t == ONE_EXT_TYPE) return CLS_ONE_EXT;
            if (t > ONE_EXT_TYPE && t <= CHOP_MAX) return CLS_CHOP;
            if (t == SAME_EXT_TYPE) return CLS_SAME_EXT;
            if (t > SAME_EXT_TYPE && t <= APPEND_MAX) return CLS_APPEND;
            if (t == TYPE_FULL) return CLS_FULL;
            return CLS_SAME;
        endfunction

        function void emit(logic [2:0] kind, logic [3:0] tag, logic [15:0] index,
                           logic [1:0] err, logic done);
            t_out_item e;
            e.event_kind     = kind;
            e.frame_class    = class_of(type_byte);
            e.frame_type_raw = type_byte;
            e.frame_offset   = delta;
            e.type_tag       = tag;
            e.tag_operand    = index;
            e.error_code     = err;
            e.frame_done     = done;
            expected_events.insert(expected_events.size(), e);
        endfunction

        // One verification type finished: count it off the list in use.
        function void type_event(logic [3:0] tag, logic [15:0] index);
            logic done;
            done = 1'b0;
            if (in_stack) begin
                stack_left = stack_left - 16'd1;
                if (stack_left == 0) begin
                    done  = 1'b1;
                    phase = P_TYPE;
                end else begin
                    phase = P_VTAG;
                end
                emit(EV_STACK, tag, index, ERR_NONE, done);
            end else begin
                locals_left = locals_left - 16'd1;
                if (locals_left != 0) begin
                    phase = P_VTAG;
                end else if (type_byte == TYPE_FULL) begin
                    phase = P_SHI;
                end else begin
                    done  = 1'b1;
                    phase = P_TYPE;
                end
                emit(EV_LOCAL, tag, index, ERR_NONE, done);
            end
        endfunction

        function void start_frame(logic [7:0] b);
            type_byte = b;
            if (b <= SAME_MAX) begin
                delta = {8'h00, b};
                phase = P_TYPE;
                emit(EV_HEADER, 4'd0, 16'd0, ERR_NONE, 1'b1);
            end else if (b <= ONE_MAX) begin
                delta      = {8'h00, b - ONE_OFFSET};
                stack_left = 16'd1;
                in_stack   = 1'b1;
                phase      = P_VTAG;
                emit(EV_HEADER, 4'd0, 16'd0, ERR_NONE, 1'b0);
            end else if (b <= RESERVED_MAX) begin
                delta    = '0;
                err_hold = 1'b1;
                phase    = P_TYPE;
                emit(EV_ERROR, 4'd0, 16'd0, ERR_RESERVED, 1'b1);
            end else begin
                phase = P_DHI;
            end
        endfunction

        function void note_byte(t_in_item it);
            logic [7:0] b;
            b = it.data_byte;
            if (it.restart) begin
                err_hold = 1'b0;
                phase    = P_TYPE;
            end
            if (err_hold) return;
            case (phase)
                P_DHI: begin
                    hi_hold = b;
                    phase   = P_DLO;
                end
                P_DLO: begin
                    delta = {hi_hold, b};
                    if (type_byte == ONE_EXT_TYPE) begin
                        stack_left = 16'd1;
                        in_stack   = 1'b1;
                        phase      = P_VTAG;
                        emit(EV_HEADER, 4'd0, 16'd0, ERR_NONE, 1'b0);
                    end else if (type_byte > SAME_EXT_TYPE && type_byte <= APPEND_MAX) begin
                        locals_left = {8'h00, type_byte - SAME_EXT_TYPE};
                        in_stack    = 1'b0;
                        phase       = P_VTAG;
                        emit(EV_HEADER, 4'd0, 16'd0, ERR_NONE, 1'b0);
                    end else if (type_byte == TYPE_FULL) begin
                        phase = P_LHI;
                        emit(EV_HEADER, 4'd0, 16'd0, ERR_NONE, 1'b0);
                    end else begin
                        phase = P_TYPE;
                        emit(EV_HEADER, 4'd0, 16'd0, ERR_NONE, 1'b1);
                    end
                end
                P_LHI: begin
                    hi_hold = b;
                    phase   = P_LLO;
                end
                P_LLO: begin
                    locals_left = {hi_hold, b};
                    in_stack    = 1'b0;
                    phase       = (locals_left != 0) ? P_VTAG : P_SHI;
                end
                P_SHI: begin
                    hi_hold = b;
                    phase   = P_SLO;
                end
                P_SLO: begin
                    stack_left = {hi_hold, b};
                    if (stack_left == 0) begin
                        phase = P_TYPE;
                        emit(EV_END, 4'd0, 16'd0, ERR_NONE, 1'b1);
                    end else begin
                        in_stack = 1'b1;
                        phase    = P_VTAG;
                    end
                end
                P_VTAG: begin
                    if (b <= VTAG_PLAIN_MAX) begin
                        type_event(b[3:0], 16'd0);
                    end else if (b <= VTAG_INDEX_MAX) begin
                        tag_hold = b[3:0];
                        phase    = P_IHI;
                    end else begin
                        err_hold = 1'b1;
                        phase    = P_TYPE;
                        emit(EV_ERROR, 4'd0, 16'd0, ERR_TAG, 1'b1);
                    end
                end
                P_IHI: begin
                    hi_hold = b;
                    phase   = P_ILO;
                end
                P_ILO: begin
                    type_event(tag_hold, {hi_hold, b});
                end
                default: begin
                    start_frame(b);
                end
            endcase
        endfunction

        function string fmt(t_out_item e);
            return $sformatf("kind=%0d class=%0d type=%0d delta=%0d tag=%0d index=%0d err=%0d done=%0d",
                             e.event_kind, e.frame_class, e.frame_type_raw, e.frame_offset,
                             e.type_tag, e.tag_operand, e.error_code, e.frame_done);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%s", msg);
        endfunction

        function void check_event(t_out_item got);
            t_out_item exp;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event: %s", fmt(got)));
                return;
            end
            exp = expected_events.pop_front();
            if (got.event_kind !== exp.event_kind || got.frame_class !== exp.frame_class ||
                got.frame_type_raw !== exp.frame_type_raw ||
                got.frame_offset !== exp.frame_offset || got.type_tag !== exp.type_tag ||
                got.tag_operand !== exp.tag_operand || got.error_code !== exp.error_code ||
                got.frame_done !== exp.frame_done) begin
                report($sformatf("event mismatch: expected %s, got %s", fmt(exp), fmt(got)));
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void check_leftover();
            while (expected_events.size() != 0)
                report($sformatf("missing event: %s", fmt(expected_events.pop_front())));
        endfunction
    endclass

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    frame_event_scoreboard sb = new;
    t_in_item stim_q[$];
    bit need_restart = 1'b0;

    stack_map_frame_parser DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_event(out_item);
    end

    initial begin
        #2_000_000;
        $display("stack_map_frame_parser_tb: FAIL");
        $finish;
    end

    function automatic void put(logic [7:0] b, bit rs = 1'b0);
        t_in_item it;
        it.data_byte = b;
        it.restart   = rs;
        stim_q.insert(stim_q.size(), it);
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void put_word(logic [15:0] w);
        put(w[15:8]);
        put(w[7:0]);
    endfunction

    // Appends one verification type; returns 1 when the tag is invalid.
    function automatic bit put_vtype();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            put(8'($urandom_range(VTAG_PLAIN_MAX)));
        end else if (r < 96) begin
            put(8'($urandom_range(VTAG_INDEX_MAX, VTAG_PLAIN_MAX + 1)));
            put_word(rand_word());
        end else begin
            put(8'($urandom_range(255, VTAG_INDEX_MAX + 1)));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 0;
        if (r < 85) return $urandom_range(4, 1);
        if (r < 96) return $urandom_range(12, 5);
        if (r < 98) return 256;
        return $urandom_range(65535, 1000);
    endfunction

    // Counts above this are cut short after a few types and resynced by restart.
    localparam int FULL_COUNT_LIMIT = 300;

    function automatic bit put_list(int n);
        for (int k = 0; k < n; k++) begin
            if (put_vtype()) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void put_frame();
        int start, r, n, drop;
        logic [7:0] t;
        bit rs, bad;
        start = stim_q.size();
        rs = ($urandom_range(15) == 0);
        if (need_restart && $urandom_range(3) != 0) rs = 1'b1;
        if (rs) need_restart = 1'b0;
        r = $urandom_range(99);
        if (r < 12) t = 8'($urandom_range(SAME_MAX));
        else if (r < 24) t = 8'($urandom_range(ONE_MAX, ONE_OFFSET));
        else if (r < 32) t = ONE_EXT_TYPE;
        else if (r < 42) t = 8'($urandom_range(CHOP_MAX, ONE_EXT_TYPE + 1));
        else if (r < 50) t = SAME_EXT_TYPE;
        else if (r < 65) t = 8'($urandom_range(APPEND_MAX, SAME_EXT_TYPE + 1));
        else if (r < 92) t = TYPE_FULL;
        else t = 8'($urandom_range(RESERVED_MAX, ONE_MAX + 1));
        put(t, rs);
        if (t > ONE_MAX && t <= RESERVED_MAX) begin
            need_restart = 1'b1;
            return;
        end
        if (t >= ONE_EXT_TYPE) put_word(rand_word());
        bad = 1'b0;
        if ((t > SAME_MAX && t <= ONE_MAX) || t == ONE_EXT_TYPE) begin
            bad = put_vtype();
        end else if (t > SAME_EXT_TYPE && t <= APPEND_MAX) begin
            bad = put_list(int'(t - SAME_EXT_TYPE));
        end else if (t == TYPE_FULL) begin
            n = rand_count();
            put_word(16'(n));
            if (n > FULL_COUNT_LIMIT) begin
                void'(put_list(3));
                need_restart = 1'b1;
                return;
            end
            bad = put_list(n);
            if (!bad) begin
                n = rand_count();
                put_word(16'(n));
                if (n > FULL_COUNT_LIMIT) begin
                    void'(put_list(3));
                    need_restart = 1'b1;
                    return;
                end
                bad = put_list(n);
            end
        end
        if (bad) need_restart = 1'b1;
        // Now and then cut the frame short or throw in stray bytes.
        if ($urandom_range(24) == 0 && stim_q.size() - start > 1) begin
            drop = $urandom_range(stim_q.size() - start - 1, 1);
            repeat (drop) void'(stim_q.pop_back());
            need_restart = 1'b1;
        end
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(3, 1)) put(8'($urandom), 1'($urandom_range(1)));
            need_restart = 1'b1;
        end
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_byte(it);
    endtask

    task automatic play(ref int sent);
        while (stim_q.size() != 0) begin
            send_item(stim_q.pop_front());
            sent++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial begin
        int sent;
        int phase_sent;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, header, stack, end and error events and both error codes.
        put(8'd0);
        put(SAME_MAX);
        put(ONE_OFFSET);
        put(8'd0);
        put(ONE_MAX);
        put(VTAG_INDEX_MAX);
        put(8'hFF);
        put(8'hFF);
        put(ONE_MAX + 8'd1);
        put(8'd5);
        put(RESERVED_MAX, 1'b1);
        put(ONE_EXT_TYPE, 1'b1);
        put(8'd0);
        put(8'd0);
        put(VTAG_INDEX_MAX + 8'd1);
        put(TYPE_FULL, 1'b1);
        put(8'hFF);
        put(8'hFF);
        put(8'd0);
        put(8'd0);
        put(8'd0);
        put(8'd0);
        put(CHOP_MAX);
        put(8'h12);
        put(8'h34);
        play(sent);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                put_frame();
                play(phase_sent);
            end
            sent += phase_sent;
            // The sender holds off here until every pending event has come out.
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        sb.check_leftover();
        if (sb.mismatches == 0) begin
            $display("stack_map_frame_parser_tb: PASS");
        end else begin
            $display("stack_map_frame_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
